/* design/segment_panel_formatter_assert.svh */
// Assertion macros for the segment panel formatter.
`ifndef SEGMENT_PANEL_FORMATTER_ASSERT_SVH
`define SEGMENT_PANEL_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPF_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/spf_pkg.sv */
`timescale 1ns / 1ps
package spf_pkg;
   localparam int unsigned NumBytes = 16;
   localparam int unsigned DigitCount = 5;

   typedef enum logic [4:0] {
      MODE_CLEAR = 5'd0, MODE_SPEED = 5'd1, MODE_MACH = 5'd2, MODE_HDG = 5'd3,
      MODE_ALT = 5'd4, MODE_VS = 5'd5, MODE_FPA = 5'd6, MODE_SPD_DASH = 5'd7,
      MODE_HDG_DASH = 5'd8, MODE_ALT_DASH = 5'd9, MODE_VRT_DASH = 5'd10,
      MODE_SPD_DOT = 5'd11, MODE_HDG_DOT = 5'd12, MODE_ALT_DOT = 5'd13,
      MODE_TRK = 5'd14, MODE_SPD_LBL = 5'd15, MODE_MACH_LBL = 5'd16,
      MODE_SPD_ONLY = 5'd17
   } mode_type;

   localparam logic [3:0] PatDash = 4'd10;
   localparam logic [3:0] PatBlank = 4'd11;
   localparam logic [3:0] PatSmall0 = 4'd12;

   // Control handed from the sequencer to the digit converter.
   typedef struct packed {
      logic        start;
      logic [16:0] value;
   } conv_req_type;

   typedef struct packed {
      logic       done;
      logic [19:0] digits;
   } conv_rsp_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] d);
      logic [7:0] p;
      case (d)
         4'd0: p = 8'hFA;
         4'd1: p = 8'h60;
         4'd2: p = 8'hBC;
         4'd3: p = 8'hF4;
         4'd4: p = 8'h66;
         4'd5: p = 8'hD6;
         4'd6: p = 8'hDE;
         4'd7: p = 8'h70;
         4'd8: p = 8'hFE;
         4'd9: p = 8'hF6;
         4'd10: p = 8'h04;
         4'd12: p = 8'hCC;
         default: p = 8'h00;
      endcase
      return p;
   endfunction
endpackage

/* design/spf_stream_if.sv */
`timescale 1ns / 1ps
interface spf_req_if;
   logic              valid;
   logic              ready;
   logic [4:0]        mode;
   logic signed [31:0] value;
   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface spf_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] lcd_address;
   logic [7:0] segment_byte;
   logic       last;
   modport source (output valid, output lcd_address, output segment_byte, output last,
                   input ready);
   modport sink (input valid, input lcd_address, input segment_byte, input last,
                 output ready);
endinterface

/* design/spf_digit_conv.sv */
`timescale 1ns / 1ps
// Shift-and-add-3 binary to BCD conversion, one bit per cycle.
module spf_digit_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  spf_pkg::conv_req_type conv_req,
   output spf_pkg::conv_rsp_type conv_rsp
);
   logic [19:0] bcd_ff, bcd_in, adj;
   logic [16:0] sh_ff, sh_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   // Add three to every digit above four before the shift.
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         adj[4*k +: 4] = (bcd_ff[4*k +: 4] > 4'd4) ? bcd_ff[4*k +: 4] + 4'd3
                                                    : bcd_ff[4*k +: 4];
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (conv_req.start) begin
         bcd_in = '0;
         sh_in = conv_req.value;
         cnt_in = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[18:0], sh_ff[16]};
         sh_in = {sh_ff[15:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      bcd_ff <= bcd_in;
      sh_ff <= sh_in;
   end

   assign conv_rsp.done = done_ff;
   assign conv_rsp.digits = bcd_ff;
endmodule

/* design/spf_sequencer.sv */
`timescale 1ns / 1ps
// Message sequencer: clamps, converts, updates the buffer and streams writes.
module spf_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sign_shown,
   spf_req_if.sink               req,
   spf_rsp_if.source             rsp,
   output spf_pkg::conv_req_type conv_req,
   input  spf_pkg::conv_rsp_type conv_rsp
);
   typedef enum logic [1:0] {IDLE, CONVERT, EMIT} state_type;

   state_type   state_ff;
   logic [7:0]  buf_ff [16];
   logic [7:0]  nb [16];
   logic [15:0] touched_ff, tin;
   logic [4:0]  mode_ff;
   logic [31:0] raw_ff;
   logic        neg_ff;
   logic [3:0]  idx_ff;
   logic [16:0] mag;
   logic        neg;
   logic        rvalid_ff, rlast_ff;
   logic [4:0]  raddr_ff;
   logic [7:0]  rbyte_ff;
   logic [15:0] rest;

   // New segments for a byte, keeping its flag bit.
   function automatic logic [7:0] with_digit(input logic [7:0] old, input logic [3:0] d);
      return spf_pkg::seg_pattern(d) | {7'd0, old[0]};
   endfunction

   // Clamp the operand to the magnitude the mode displays.
   always_comb begin
      logic signed [15:0] s16;
      logic signed [7:0]  s8;
      s16 = req.value[15:0];
      s8 = req.value[7:0];
      mag = '0;
      neg = 1'b0;
      case (req.mode)
         spf_pkg::MODE_SPEED, spf_pkg::MODE_MACH, spf_pkg::MODE_HDG,
         spf_pkg::MODE_SPD_ONLY:
            mag = (req.value[15:0] > 16'd999) ? 17'd999 : {1'b0, req.value[15:0]};
         spf_pkg::MODE_ALT:
            mag = (req.value[31:0] > 32'd99999) ? 17'd99999 : req.value[16:0];
         spf_pkg::MODE_VS: begin
            neg = s16 < 0;
            if (s16 > 16'sd9999 || s16 < -16'sd9999) mag = 17'd9999;
            else mag = neg ? {1'b0, -s16} : {1'b0, s16};
         end
         spf_pkg::MODE_FPA: begin
            neg = s8 < 0;
            if (s8 > 8'sd99 || s8 < -8'sd99) mag = 17'd99;
            else mag = neg ? {9'd0, -s8} : {9'd0, s8};
         end
         default: mag = '0;
      endcase
   end

   // Apply the message to a copy of the buffer once digits are known.
   always_comb begin
      logic [19:0] dg;
      logic        fl, sg;
      dg = conv_rsp.digits;
      fl = raw_ff[7:0] != 8'd0;
      sg = sign_shown;
      tin = '0;
      for (int k = 0; k < 16; k++) nb[k] = buf_ff[k];
      case (mode_ff)
         spf_pkg::MODE_CLEAR: begin
            for (int k = 0; k < 16; k++) nb[k] = '0;
            tin = 16'hFFFF;
         end
         spf_pkg::MODE_SPEED, spf_pkg::MODE_MACH, spf_pkg::MODE_SPD_ONLY: begin
            if (mode_ff != spf_pkg::MODE_SPD_ONLY) begin
               nb[15][7] = mode_ff == spf_pkg::MODE_SPEED;
               nb[15][6] = mode_ff == spf_pkg::MODE_MACH;
               nb[1][0] = mode_ff == spf_pkg::MODE_MACH;
               tin[15] = 1'b1;
            end
            for (int k = 0; k < 3; k++)
               nb[2-k] = with_digit(nb[2-k], dg[4*k +: 4]);
            tin[2:0] = 3'b111;
         end
         spf_pkg::MODE_HDG: begin
            for (int k = 0; k < 3; k++)
               nb[5-k] = with_digit(nb[5-k], dg[4*k +: 4]);
            tin[5:3] = 3'b111;
         end
         spf_pkg::MODE_ALT: begin
            for (int k = 0; k < 5; k++)
               nb[10-k] = with_digit(nb[10-k], dg[4*k +: 4]);
            tin[10:6] = 5'b11111;
         end
         spf_pkg::MODE_VS: begin
            if (neg_ff) begin
               nb[13][0] = 1'b0;
               nb[14][0] = sg;
            end else if (raw_ff[15:0] == 16'd0) begin
               nb[13][0] = 1'b0;
               nb[14][0] = 1'b0;
            end else begin
               nb[13][0] = sg;
               nb[14][0] = sg;
            end
            nb[12][0] = 1'b0;
            nb[14] = with_digit(nb[14], spf_pkg::PatSmall0);
            nb[13] = with_digit(nb[13], spf_pkg::PatSmall0);
            nb[12] = with_digit(nb[12], dg[11:8]);
            nb[11] = with_digit(nb[11], dg[15:12]);
            tin[14:11] = 4'b1111;
         end
         spf_pkg::MODE_FPA: begin
            nb[13] = {7'd0, neg_ff ? 1'b0 : sg};
            nb[14] = {7'd0, sg};
            nb[12] = spf_pkg::seg_pattern(dg[3:0]) | 8'h01;
            nb[11] = with_digit(nb[11], dg[7:4]);
            tin[14:11] = 4'b1111;
         end
         spf_pkg::MODE_SPD_DASH: begin
            for (int k = 0; k < 3; k++)
               nb[k] = with_digit(nb[k], fl ? spf_pkg::PatDash : spf_pkg::PatBlank);
            nb[1][0] = 1'b0;
            tin[2:0] = 3'b111;
         end
         spf_pkg::MODE_HDG_DASH: begin
            for (int k = 3; k < 6; k++)
               nb[k] = with_digit(nb[k], fl ? spf_pkg::PatDash : spf_pkg::PatBlank);
            tin[5:3] = 3'b111;
         end
         spf_pkg::MODE_ALT_DASH: begin
            for (int k = 6; k < 11; k++)
               nb[k] = with_digit(nb[k], fl ? spf_pkg::PatDash : spf_pkg::PatBlank);
            tin[10:6] = 5'b11111;
         end
         spf_pkg::MODE_VRT_DASH: begin
            nb[14][0] = fl;
            if (fl) nb[13][0] = 1'b0;
            for (int k = 11; k < 15; k++)
               nb[k] = with_digit(nb[k], fl ? spf_pkg::PatDash : spf_pkg::PatBlank);
            tin[14:11] = 4'b1111;
         end
         spf_pkg::MODE_SPD_DOT: begin
            nb[3][0] = fl;
            tin[3] = 1'b1;
         end
         spf_pkg::MODE_HDG_DOT: begin
            nb[5][0] = fl;
            tin[5] = 1'b1;
         end
         spf_pkg::MODE_ALT_DOT: begin
            nb[11][0] = fl;
            tin[11] = 1'b1;
         end
         spf_pkg::MODE_TRK: begin
            nb[15][5] = !fl;
            nb[15][4] = fl;
            nb[15][2] = !fl;
            nb[15][3] = fl;
            nb[9][0] = !fl;
            nb[8][0] = fl;
            nb[7][0] = !fl;
            nb[6][0] = fl;
            tin[15] = 1'b1;
            tin[9:6] = 4'b1111;
         end
         spf_pkg::MODE_SPD_LBL: begin
            nb[15][7] = fl;
            tin[15] = 1'b1;
         end
         spf_pkg::MODE_MACH_LBL: begin
            nb[15][6] = fl;
            nb[1][0] = fl;
            tin[15] = 1'b1;
            tin[1] = 1'b1;
         end
         default: tin = '0;
      endcase
   end

   // Touched bits above the current index, for the last flag.
   always_comb begin
      rest = '0;
      for (int k = 0; k < 16; k++) rest[k] = touched_ff[k] && (k > 32'(idx_ff));
   end

   assign req.ready = (state_ff == IDLE) && !rvalid_ff;
   assign conv_req.start = req.valid && req.ready;
   assign conv_req.value = mag;
   assign rsp.valid = rvalid_ff;
   assign rsp.lcd_address = raddr_ff;
   assign rsp.segment_byte = rbyte_ff;
   assign rsp.last = rlast_ff;

   // State, buffer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rvalid_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            if (k == 15) buf_ff[k] <= 8'h03;
            else if (k == 4) buf_ff[k] <= 8'h01;
            else buf_ff[k] <= '0;
         end
         touched_ff <= '0;
         idx_ff <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (rvalid_ff && rsp.ready) rvalid_ff <= 1'b0;
               if (req.valid && req.ready) begin
                  mode_ff <= req.mode;
                  raw_ff <= req.value;
                  neg_ff <= neg;
                  state_ff <= CONVERT;
               end
            end
            CONVERT: begin
               if (conv_rsp.done) begin
                  for (int k = 0; k < 16; k++) buf_ff[k] <= nb[k];
                  touched_ff <= tin;
                  idx_ff <= '0;
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (!rvalid_ff || rsp.ready) begin
                  rvalid_ff <= touched_ff[idx_ff];
                  if (touched_ff[idx_ff]) begin
                     raddr_ff <= {idx_ff, 1'b0};
                     rbyte_ff <= buf_ff[idx_ff];
                     rlast_ff <= rest == '0;
                  end
                  idx_ff <= idx_ff + 4'd1;
                  if (idx_ff == 4'd15) state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

/* design/segment_panel_formatter.sv */
`timescale 1ns / 1ps
// Segment panel formatter. An accepted message passes through the
// bit-serial decimal converter and its hand-off (17 conversion steps), then the
// sequencer scans the 16 buffer bytes at one per cycle while writes stream out.
// The next message is accepted only after the scan has finished and any
// pending write has been taken by the receiver downstream; a stalled write
// holds the scan. The converter runs for every message, including clears and
// flag messages. Writes come in ascending address order with last on the final
// one; a message that touches nothing emits none. sign_shown may be written
// whenever the block is idle.
`include "segment_panel_formatter_assert.svh"
module segment_panel_formatter (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   spf_req_if.sink    req,
   spf_rsp_if.source  rsp
);
   logic                  sign_ff;
   spf_pkg::conv_req_type conv_req;
   spf_pkg::conv_rsp_type conv_rsp;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) sign_ff <= 1'b0;
      else if (csr_write_enable) sign_ff <= csr_write_data;
   end

   spf_digit_conv u_conv (
      .clock(clock), .reset(reset), .conv_req(conv_req), .conv_rsp(conv_rsp));

   spf_sequencer u_seq (
      .clock(clock), .reset(reset), .sign_shown(sign_ff), .req(req), .rsp(rsp),
      .conv_req(conv_req), .conv_rsp(conv_rsp));

   `SPF_ASSERT_IMP(a_no_accept_while_out, clock, reset, rsp.valid, !req.ready)
   `SPF_ASSERT_NEXT(a_start_busy, clock, reset, req.valid && req.ready, !req.ready)
endmodule
